// ----- hdl/glos_pkg.sv -----
// Shared types, sizes and helpers for the grid line-of-sight checker.
package glos_pkg;

  localparam int GRID_COLS  = 128;
  localparam int GRID_ROWS  = 64;
  localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  localparam int X_W   = 7;
  localparam int Y_W   = 6;
  localparam int XY_W  = (X_W > Y_W) ? X_W : Y_W;
  localparam int ERR_W = XY_W + 3;
  localparam int CNT_W = XY_W + 2;

  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 8;
  localparam int TYPE_W   = 2;

  typedef logic [X_W-1:0] coord_x_t;
  typedef logic [Y_W-1:0] coord_y_t;

  typedef enum logic [TYPE_W-1:0] {
    REQ_WRITE = 2'd0,
    REQ_LOS   = 2'd1,
    REQ_MOVE  = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_LINE,
    ST_MOVE,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic mem_wr;
    logic line_step;
    logic move_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic line_last;
    logic move_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [ADDR_W-1:0] cell_addr(coord_x_t x, coord_y_t y);
    return ADDR_W'(ADDR_W'(y) * ADDR_W'(GRID_COLS) + ADDR_W'(x));
  endfunction

  function automatic logic in_grid(coord_x_t x, coord_y_t y);
    return (32'(x) < GRID_COLS) && (32'(y) < GRID_ROWS);
  endfunction

endpackage

// ----- hdl/glos_ctrl.sv -----
// Controller state machine of the grid line-of-sight checker.
module glos_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_valid_i,
  input  logic [glos_pkg::TYPE_W-1:0]  req_type_i,
  output logic                         s_ready_o,
  input  glos_pkg::dp_status_t         status_i,
  output glos_pkg::ctrl_cmd_t          cmd_o
);

  glos_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= glos_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      glos_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) state_d = glos_pkg::ST_IDLE;
      end
      glos_pkg::ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          case (req_type_i)
            glos_pkg::REQ_WRITE: state_d = glos_pkg::ST_WRITE;
            glos_pkg::REQ_LOS:   state_d = glos_pkg::ST_LINE;
            glos_pkg::REQ_MOVE:  state_d = glos_pkg::ST_MOVE;
            default:             state_d = glos_pkg::ST_RESULT;
          endcase
        end
      end
      glos_pkg::ST_WRITE: begin
        cmd_o.mem_wr = 1'b1;
        state_d      = glos_pkg::ST_RESULT;
      end
      glos_pkg::ST_LINE: begin
        cmd_o.line_step = 1'b1;
        if (status_i.line_last) state_d = glos_pkg::ST_DRAIN;
      end
      glos_pkg::ST_MOVE: begin
        cmd_o.move_step = 1'b1;
        if (status_i.move_last) state_d = glos_pkg::ST_DRAIN;
      end
      glos_pkg::ST_DRAIN: begin
        state_d = glos_pkg::ST_RESULT;
      end
      glos_pkg::ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = glos_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = glos_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- hdl/glos_dp.sv -----
// Datapath: occupancy map, line stepper, move-check addressing and output register.
module glos_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  glos_pkg::ctrl_cmd_t          cmd_i,
  output glos_pkg::dp_status_t         status_o,
  input  logic [glos_pkg::TYPE_W-1:0]  in_type_i,
  input  glos_pkg::coord_x_t           in_x0_i,
  input  glos_pkg::coord_y_t           in_y0_i,
  input  glos_pkg::coord_x_t           in_x1_i,
  input  glos_pkg::coord_y_t           in_y1_i,
  input  logic                         in_blocked_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [glos_pkg::TYPE_W-1:0]  out_type_o,
  output logic                         out_clear_o
);

  localparam int ADDR_W = glos_pkg::ADDR_W;
  localparam int ERR_W  = glos_pkg::ERR_W;
  localparam int CNT_W  = glos_pkg::CNT_W;

  // Latched request
  logic [glos_pkg::TYPE_W-1:0] type_q;
  glos_pkg::coord_x_t          x0_q, x1_q;
  glos_pkg::coord_y_t          y0_q, y1_q;
  logic                        blocked_q;

  // Line stepper
  glos_pkg::coord_x_t          cx_q, dx_q, dx_in;
  glos_pkg::coord_y_t          cy_q, dy_q, dy_in;
  logic                        sx_neg_q, sy_neg_q;
  logic signed [ERR_W-1:0]     err_q;
  logic [CNT_W-1:0]            cnt_q;
  logic signed [ERR_W-1:0]     dx2, dy2;

  // Move check
  logic [1:0]                  midx_q;
  logic                        move_diag;

  // Map and read path
  logic                        mem_q [glos_pkg::CELL_COUNT];
  logic [ADDR_W-1:0]           clr_q;
  logic                        rdata_q, rd_valid_q, hit_q;
  logic                        rd_en, wr_en, wr_data;
  logic [ADDR_W-1:0]           wr_addr;
  glos_pkg::coord_x_t          rx;
  glos_pkg::coord_y_t          ry;

  // Output register
  logic                        out_valid_q, out_clear_q;
  logic [glos_pkg::TYPE_W-1:0] out_type_q;

  assign dx_in = (in_x1_i > in_x0_i) ? in_x1_i - in_x0_i : in_x0_i - in_x1_i;
  assign dy_in = (in_y1_i > in_y0_i) ? in_y1_i - in_y0_i : in_y0_i - in_y1_i;
  assign dx2   = ERR_W'({dx_q, 1'b0});
  assign dy2   = ERR_W'({dy_q, 1'b0});

  assign move_diag = (x0_q != x1_q) && (y0_q != y1_q);

  // Read address select
  always_comb begin
    rx = cx_q;
    ry = cy_q;
    if (cmd_i.move_step) begin
      case (midx_q)
        2'd0:    begin rx = x0_q; ry = y0_q; end
        2'd1:    begin rx = x1_q; ry = y1_q; end
        2'd2:    begin rx = x0_q; ry = y1_q; end
        default: begin rx = x1_q; ry = y0_q; end
      endcase
    end
  end

  assign rd_en = cmd_i.line_step || cmd_i.move_step;

  // Write port: clearing pass or a cell write inside the grid
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_q;
    wr_data = 1'b0;
    if (cmd_i.clr_step) begin
      wr_en = 1'b1;
    end else if (cmd_i.mem_wr && glos_pkg::in_grid(x0_q, y0_q)) begin
      wr_en   = 1'b1;
      wr_addr = glos_pkg::cell_addr(x0_q, y0_q);
      wr_data = blocked_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem_q[glos_pkg::cell_addr(rx, ry)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      rd_valid_q <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + ADDR_W'(1);
      rd_valid_q <= rd_en && glos_pkg::in_grid(rx, ry);
      if (cmd_i.accept) begin
        hit_q <= 1'b0;
      end else if (rd_valid_q && rdata_q) begin
        hit_q <= 1'b1;
      end
    end
  end

  // Request latch and stepper
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      type_q    <= in_type_i;
      x0_q      <= in_x0_i;
      y0_q      <= in_y0_i;
      x1_q      <= in_x1_i;
      y1_q      <= in_y1_i;
      blocked_q <= in_blocked_i;
      cx_q      <= in_x0_i;
      cy_q      <= in_y0_i;
      dx_q      <= dx_in;
      dy_q      <= dy_in;
      sx_neg_q  <= !(in_x1_i > in_x0_i);
      sy_neg_q  <= !(in_y1_i > in_y0_i);
      err_q     <= ERR_W'(dx_in) - ERR_W'(dy_in);
      cnt_q     <= CNT_W'(dx_in) + CNT_W'(dy_in) + CNT_W'(1);
      midx_q    <= 2'd0;
    end else begin
      if (cmd_i.move_step) midx_q <= midx_q + 2'd1;
      if (cmd_i.line_step) begin
        if (err_q > 0) begin
          cx_q  <= sx_neg_q ? cx_q - glos_pkg::coord_x_t'(1) : cx_q + glos_pkg::coord_x_t'(1);
          err_q <= err_q - dy2;
          cnt_q <= cnt_q - CNT_W'(1);
        end else if (err_q < 0) begin
          cy_q  <= sy_neg_q ? cy_q - glos_pkg::coord_y_t'(1) : cy_q + glos_pkg::coord_y_t'(1);
          err_q <= err_q + dx2;
          cnt_q <= cnt_q - CNT_W'(1);
        end else begin
          // Diagonal step consumes two counts
          cx_q  <= sx_neg_q ? cx_q - glos_pkg::coord_x_t'(1) : cx_q + glos_pkg::coord_x_t'(1);
          cy_q  <= sy_neg_q ? cy_q - glos_pkg::coord_y_t'(1) : cy_q + glos_pkg::coord_y_t'(1);
          err_q <= err_q + dx2 - dy2;
          cnt_q <= cnt_q - CNT_W'(2);
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_type_q  <= type_q;
      out_clear_q <= ((type_q == glos_pkg::REQ_LOS) || (type_q == glos_pkg::REQ_MOVE))
                     && !hit_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_type_o  = out_type_q;
  assign out_clear_o = out_clear_q;

  assign status_o.clr_last  = (clr_q == ADDR_W'(glos_pkg::CELL_COUNT - 1));
  assign status_o.line_last = (cnt_q <= CNT_W'(1)) || ((err_q == 0) && (cnt_q == CNT_W'(2)));
  assign status_o.move_last = (midx_q == 2'd3) || ((midx_q == 2'd1) && !move_diag);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ----- hdl/grid_line_of_sight_checker_top.sv -----
// Top level of the grid line-of-sight checker: stream ports, controller and datapath.
// Throughput: one request at a time; the line stepper reads one map cell per cycle from
//   the single read port of the map memory, which sets the query time.
// Reset: asynchronous, active low; a clearing pass over all map cells follows, s_axis_tready low.
module grid_line_of_sight_checker_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request channel
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [6:0] start_x, [12:7] start_y, [19:13] end_x, [25:20] end_y, [26] cell_blocked
  input  logic [glos_pkg::S_DATA_W-1:0]    s_axis_tdata,
  // [1:0] req_type
  input  logic [glos_pkg::TYPE_W-1:0]      s_axis_tuser,
  // Result channel
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] path_clear
  output logic [glos_pkg::M_DATA_W-1:0]    m_axis_tdata,
  // [1:0] answered_type
  output logic [glos_pkg::TYPE_W-1:0]      m_axis_tuser
);

  glos_pkg::ctrl_cmd_t  cmd;
  glos_pkg::dp_status_t status;
  logic                 path_clear;

  // Controller: sequences clearing, cell writes, line walking, move checks and result hand-off
  glos_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .req_type_i (s_axis_tuser),
    .s_ready_o  (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: unpack the request fields straight from tdata
  glos_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_type_i    (s_axis_tuser),
    .in_x0_i      (s_axis_tdata[6:0]),
    .in_y0_i      (s_axis_tdata[12:7]),
    .in_x1_i      (s_axis_tdata[19:13]),
    .in_y1_i      (s_axis_tdata[25:20]),
    .in_blocked_i (s_axis_tdata[26]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_type_o   (m_axis_tuser),
    .out_clear_o  (path_clear)
  );

  // Pad the result flag to a whole byte
  assign m_axis_tdata = {{(glos_pkg::M_DATA_W-1){1'b0}}, path_clear};

endmodule
